// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the cache RTL modules.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/lbwc_pkg.sv -----
// Shared types and constants of the LRU block word cache.
// Depends on nothing; used by the controller, datapath and top level.
`default_nettype none

package lbwc_pkg;

  localparam int BLOCK_BYTES_DEF = 64;
  localparam int BLOCK_COUNT_DEF = 16;
  localparam int WORD_W          = 64;
  localparam int ADDR_W          = 64;
  localparam int FWI_W           = 3;
  localparam int IN_DATA_W       = 136;
  localparam int OUT_DATA_W      = 128;

  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_FILL_WORD  = 2'd1,
    OP_FILL_DONE  = 2'd2,
    OP_INVALIDATE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_VALUE      = 3'd0,
    ST_UNREADABLE = 3'd1,
    ST_FILL_REQ   = 3'd2,
    ST_BYPASS     = 3'd3
  } stat_t;

  typedef struct packed {
    logic  take;
    logic  tag_cmp;
    logic  order_upd;
    logic  mem_rd;
    logic  rd_pend;
    logic  load_out;
    stat_t kind;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic straddle;
    logic pend_valid;
    logic fill_readable;
    logic hit;
    logic hit_readable;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/lbwc_ctrl.sv -----
// Controller state machine of the LRU block word cache.
// Depends on lbwc_pkg and assert_macros.svh; drives the datapath by commands.
`default_nettype none
`include "assert_macros.svh"

module lbwc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire lbwc_pkg::sts_t sts,
  output lbwc_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TAG   = 5'b00010,
    S_ORDER = 5'b00100,
    S_READ  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t          state, state_next;
  lbwc_pkg::stat_t kind, kind_next;
  logic            src_pend, src_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      kind     <= lbwc_pkg::ST_VALUE;
      src_pend <= 1'b0;
    end else begin
      state    <= state_next;
      kind     <= kind_next;
      src_pend <= src_pend_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    kind_next     = kind;
    src_pend_next = src_pend;
    cmd           = '0;
    cmd.kind      = kind;
    cmd.rd_pend   = src_pend;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take = 1'b1;
          unique case (sts.op)
            lbwc_pkg::OP_LOOKUP: begin
              if (sts.straddle) begin
                kind_next  = lbwc_pkg::ST_BYPASS;
                state_next = S_EMIT;
              end else begin
                state_next = S_TAG;
              end
            end
            lbwc_pkg::OP_FILL_DONE: begin
              if (sts.pend_valid) begin
                if (sts.fill_readable) begin
                  src_pend_next = 1'b1;
                  state_next    = S_READ;
                end else begin
                  kind_next  = lbwc_pkg::ST_UNREADABLE;
                  state_next = S_EMIT;
                end
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_TAG: begin
        cmd.tag_cmp = 1'b1;
        state_next  = S_ORDER;
      end
      S_ORDER: begin
        cmd.order_upd = 1'b1;
        if (sts.hit && sts.hit_readable) begin
          src_pend_next = 1'b0;
          state_next    = S_READ;
        end else if (sts.hit) begin
          kind_next  = lbwc_pkg::ST_UNREADABLE;
          state_next = S_EMIT;
        end else begin
          kind_next  = lbwc_pkg::ST_FILL_REQ;
          state_next = S_EMIT;
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        kind_next  = lbwc_pkg::ST_VALUE;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_NXT(a_emit_waits, clk, rst, (state == S_EMIT) && !sts.out_free, state == S_EMIT)
  `ASSERT_NXT(a_tag_then_order, clk, rst, state == S_TAG, state == S_ORDER)
  `ASSERT_IMP(a_load_when_free, clk, rst, cmd.load_out, sts.out_free)

endmodule

`default_nettype wire

// ----- hdl/lbwc_dpath.sv -----
// Datapath of the LRU block word cache: tags, recency list, block data memory.
// Depends on lbwc_pkg and assert_macros.svh; steered by lbwc_ctrl commands.
`default_nettype none
`include "assert_macros.svh"

module lbwc_dpath #(
  parameter int BLOCK_BYTES = lbwc_pkg::BLOCK_BYTES_DEF,
  parameter int BLOCK_COUNT = lbwc_pkg::BLOCK_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [lbwc_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [1:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [lbwc_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [2:0]                         m_tuser,
  input  wire lbwc_pkg::cmd_t                cmd,
  output lbwc_pkg::sts_t                     sts
);

  localparam int OW    = $clog2(BLOCK_BYTES);
  localparam int WW    = OW - 3;
  localparam int TW    = lbwc_pkg::ADDR_W - OW;
  localparam int EW    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int LW    = $clog2(BLOCK_COUNT + 1);
  localparam int AW    = EW + WW;
  localparam int DEPTH = BLOCK_COUNT * (BLOCK_BYTES / 8);
  localparam logic [OW-1:0] OFF_MAX = OW'(BLOCK_BYTES - 8);
  localparam logic [LW-1:0] LEN_FULL = LW'(BLOCK_COUNT);

  logic [lbwc_pkg::ADDR_W-1:0] in_addr;
  logic [lbwc_pkg::WORD_W-1:0] in_fdata;
  logic [lbwc_pkg::FWI_W-1:0]  in_fwi;
  logic                        in_frd;
  lbwc_pkg::op_t               in_op;

  assign in_addr  = s_tdata[63:0];
  assign in_fdata = s_tdata[127:64];
  assign in_fwi   = s_tdata[130:128];
  assign in_frd   = s_tdata[131];
  assign in_op    = lbwc_pkg::op_t'(s_tuser);

  logic [TW-1:0]              tag_mem [BLOCK_COUNT];
  logic [BLOCK_COUNT-1:0]     valid, readable;
  logic [EW-1:0]              order [BLOCK_COUNT];
  logic [LW-1:0]              len;
  logic                       pend_valid;
  logic [EW-1:0]              pend_ent;
  logic [OW-1:0]              pend_off;
  logic [TW-1:0]              tag_l;
  logic [OW-1:0]              off_l;
  logic                       hit, hit_rd;
  logic [EW-1:0]              hit_ent;
  logic [lbwc_pkg::WORD_W-1:0] mem [DEPTH];
  logic [lbwc_pkg::WORD_W-1:0] rd0, rd1;
  logic [2:0]                 rd_sh;

  logic [BLOCK_COUNT-1:0] match;
  logic [EW-1:0]          hit_ent_c;
  logic [EW-1:0]          pos_c, front_c, pos_sel;
  logic                   full;
  logic [EW-1:0]          rd_ent;
  logic [OW-1:0]          rd_off;
  logic [WW-1:0]          rd_w, rd_w1, fill_idx;
  logic [2*lbwc_pkg::WORD_W-1:0] shifted;

  assign full = (len == LEN_FULL);

  always_comb begin
    match     = '0;
    hit_ent_c = '0;
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      match[i] = valid[i] && (tag_mem[i] == tag_l);
      if (match[i]) begin
        hit_ent_c = hit_ent_c | EW'(i);
      end
    end
  end

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      if ((LW'(i) < len) && (order[i] == hit_ent)) begin
        pos_c = pos_c | EW'(i);
      end
    end
  end

  always_comb begin
    if (hit) begin
      pos_sel = pos_c;
      front_c = hit_ent;
    end else if (full) begin
      pos_sel = EW'(BLOCK_COUNT - 1);
      front_c = order[BLOCK_COUNT - 1];
    end else begin
      pos_sel = len[EW-1:0];
      front_c = len[EW-1:0];
    end
  end

  assign rd_ent   = cmd.rd_pend ? pend_ent : hit_ent;
  assign rd_off   = cmd.rd_pend ? pend_off : off_l;
  assign rd_w     = rd_off[OW-1:3];
  assign rd_w1    = rd_w + WW'(1);
  assign fill_idx = WW'(in_fwi);
  assign shifted  = {rd1, rd0} >> {rd_sh, 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      readable   <= '0;
      len        <= '0;
      pend_valid <= 1'b0;
      pend_ent   <= '0;
      pend_off   <= '0;
    end else if (cmd.take) begin
      unique case (in_op)
        lbwc_pkg::OP_FILL_DONE: begin
          if (pend_valid) begin
            pend_valid         <= 1'b0;
            valid[pend_ent]    <= 1'b1;
            readable[pend_ent] <= in_frd;
          end
        end
        lbwc_pkg::OP_INVALIDATE: begin
          valid      <= '0;
          readable   <= '0;
          len        <= '0;
          pend_valid <= 1'b0;
        end
        default: begin
          pend_valid <= pend_valid;
        end
      endcase
    end else if (cmd.order_upd && !hit) begin
      valid[front_c]    <= 1'b0;
      readable[front_c] <= 1'b0;
      pend_valid        <= 1'b1;
      pend_ent          <= front_c;
      pend_off          <= off_l;
      if (!full) begin
        len <= len + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      tag_l <= in_addr[lbwc_pkg::ADDR_W-1:OW];
      off_l <= in_addr[OW-1:0];
    end
    if (cmd.tag_cmp) begin
      hit     <= |match;
      hit_rd  <= |(match & readable);
      hit_ent <= hit_ent_c;
    end
    if (cmd.order_upd) begin
      order[0] <= front_c;
      for (int i = 1; i < BLOCK_COUNT; i++) begin
        if (EW'(i) <= pos_sel) begin
          order[i] <= order[i-1];
        end
      end
      if (!hit) begin
        tag_mem[front_c] <= tag_l;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && (in_op == lbwc_pkg::OP_FILL_WORD) && pend_valid) begin
      mem[{pend_ent, fill_idx}] <= in_fdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd0   <= mem[AW'({rd_ent, rd_w})];
      rd1   <= mem[AW'({rd_ent, rd_w1})];
      rd_sh <= rd_off[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tuser        <= cmd.kind;
      m_tdata[63:0]  <= (cmd.kind == lbwc_pkg::ST_VALUE) ? shifted[63:0] : '0;
      m_tdata[127:64] <= (cmd.kind == lbwc_pkg::ST_FILL_REQ) ? {tag_l, {OW{1'b0}}} : '0;
    end
  end

  always_comb begin
    sts               = '0;
    sts.op            = in_op;
    sts.straddle      = in_addr[OW-1:0] > OFF_MAX;
    sts.pend_valid    = pend_valid;
    sts.fill_readable = in_frd;
    sts.hit           = hit;
    sts.hit_readable  = hit_rd;
    sts.out_free      = !m_tvalid || m_tready;
  end

  `ASSERT_IMP(a_len_bound, clk, rst, 1'b1, len <= LEN_FULL)
  `ASSERT_NXT(a_miss_pends, clk, rst, cmd.order_upd && !hit, pend_valid)
  `ASSERT_IMP(a_hit_is_valid, clk, rst, cmd.order_upd && hit, valid[hit_ent])

endmodule

`default_nettype wire

// ----- hdl/lru_block_word_cache_unit.sv -----
// Top level of the LRU block word cache: controller plus datapath.
// Depends on lbwc_pkg, lbwc_ctrl and lbwc_dpath.
//
//   channel  direction  tdata                          tuser
//   s_*      in         items: lookups, fills, clears  opcode
//   m_*      out        results                        status
//
// A readable hit passes tag, order, read and emit; a miss or unreadable hit skips
// the read; a straddling lookup or unreadable fill done emits at once, a readable one
// reads first; other items end in idle. The data memory's read port is registered.
// Reset is synchronous and clears the valid marks, list and fill.
// A result waits in the output register while m_tready is low; the block holds
// its next result until that register is free.
`default_nettype none

module lru_block_word_cache_unit #(
  parameter int BLOCK_BYTES = lbwc_pkg::BLOCK_BYTES_DEF,
  parameter int BLOCK_COUNT = lbwc_pkg::BLOCK_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // slot_address, fill_data, fill_word_index, fill_readable, zero pad
  input  wire logic [lbwc_pkg::IN_DATA_W-1:0] s_tdata,
  // opcode
  input  wire logic [1:0]                     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // word_value, fill_base
  output logic [lbwc_pkg::OUT_DATA_W-1:0]     m_tdata,
  // status
  output logic [2:0]                          m_tuser
);

  lbwc_pkg::cmd_t cmd;
  lbwc_pkg::sts_t sts;

  lbwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbwc_dpath #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire
